@@ sv/psu_pkg.sv @@
// Package for the PNG scanline unfilter: filter codes, register map, defaults, Paeth predictor.
`timescale 1ns / 1ps

package psu_pkg;

  localparam int MAX_ROW_BYTES_DEF = 16384;

  localparam logic [2:0] FILT_NONE  = 3'h0;
  localparam logic [2:0] FILT_SUB   = 3'h1;
  localparam logic [2:0] FILT_UP    = 3'h2;
  localparam logic [2:0] FILT_AVG   = 3'h3;
  localparam logic [2:0] FILT_PAETH = 3'h4;

  localparam logic [7:0] FILT_MAX_BYTE = 8'h04;

  localparam int         PADDR_W        = 3;
  localparam logic       REG_IMAGE_WIDTH = 1'b0;
  localparam logic       REG_COLOR_MODE  = 1'b1;

  localparam logic [12:0] IMAGE_WIDTH_RST = 13'd640;
  localparam logic        COLOR_MODE_RST  = 1'b0;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [7:0] pick;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      pick = a;
    end else if (pb <= pc) begin
      pick = b;
    end else begin
      pick = c;
    end
    return pick;
  endfunction

endpackage

@@ sv/png_scanline_unfilter_top.sv @@
// PNG scanline unfilter for 8-bit grayscale and RGB images, with its row memory.
`timescale 1ns / 1ps

// Input channel: one filtered byte per item on in_data_byte; in_start_of_image
// marks the filter byte of row zero. The first byte of every row selects the
// filter and produces no output item; every later byte produces one
// reconstructed byte, with out_last_in_row on the final byte of the row.
// A filter byte above 4 produces one item with out_bad_filter set, and bytes
// are dropped until the next start of image.
// Throughput: one item per cycle while the output is not stalled; the row memory
// has a read port, used when an item is accepted, and a separate write port,
// used when the item leaves the second stage. An accepted item passes through
// the second-stage register and then the output register.
// Output stall: the output register holds its item, the stage behind it holds,
// and in_stall rises only when both are full.
// Reset (rst_n low, synchronous) clears the pipeline, the histories and the row
// state; image_width returns to 640 and color_mode to grayscale. The row
// memory is not cleared; row zero does not use what it reads from it.
// Configuration: APB writes at byte address 0 (image_width) and 4 (color_mode),
// done while no item is in flight.
module png_scanline_unfilter_top #(
  parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_start_of_image,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_pixel_byte,
  output logic                        out_last_in_row,
  output logic                        out_bad_filter,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psu_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int AW    = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int CW    = $clog2(MAX_ROW_BYTES + 1);
  localparam int LEN_W = (CW > 15) ? CW : 15;

  typedef enum logic [1:0] {
    KIND_FILT = 2'd0,
    KIND_BAD  = 2'd1,
    KIND_DATA = 2'd2
  } kind_t;

  logic [12:0]   image_width_r;
  logic          color_mode_r;

  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [2:0]    filt_r, filt_nxt;
  logic          first_row_r, first_row_nxt;
  logic          halted_r, halted_nxt;

  logic          s2_valid_r;
  kind_t         s2_kind_r;
  logic [7:0]    s2_byte_r;
  logic [AW-1:0] s2_col_r;
  logic          s2_last_r;
  logic          s2_first_r;
  logic [2:0]    s2_filt_r;

  logic [7:0]    left_r [3];
  logic [7:0]    upleft_r [3];

  logic          out_valid_r;
  logic [7:0]    out_pixel_r;
  logic          out_last_r;
  logic          out_bad_r;

  logic [7:0]    row_mem [MAX_ROW_BYTES];
  logic [7:0]    rd_data_r;

  logic              accept;
  logic              s2_go;
  logic              cfg_wr;
  logic [12:0]       width_eff;
  logic [LEN_W-1:0]  width_ext;
  logic [LEN_W-1:0]  row_raw;
  logic [LEN_W-1:0]  row_len;
  logic [CW-1:0]     cnt_eff;
  logic              halted_eff;
  logic              first_row_eff;
  logic              drop;
  kind_t             kind;
  logic [AW-1:0]     col;
  logic              last;
  logic              rd_en;
  logic              wr_en;
  logic [7:0]        pa_a, pa_b, pa_c, pred, recon;
  logic [8:0]        avg_sum;
  logic [1:0]        tap;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == psu_pkg::REG_COLOR_MODE) ? {31'b0, color_mode_r}
                                                        : {19'b0, image_width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= psu_pkg::IMAGE_WIDTH_RST;
      color_mode_r  <= psu_pkg::COLOR_MODE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == psu_pkg::REG_IMAGE_WIDTH) begin
        image_width_r <= pwdata[12:0];
      end else begin
        color_mode_r <= pwdata[0];
      end
    end
  end

  assign width_eff = (image_width_r == 13'd0) ? 13'd1 : image_width_r;
  assign width_ext = LEN_W'(width_eff);
  assign row_raw   = color_mode_r ? (width_ext << 1) + width_ext : width_ext;
  assign row_len   = (row_raw > LEN_W'(MAX_ROW_BYTES)) ? LEN_W'(MAX_ROW_BYTES) : row_raw;

  assign s2_go    = s2_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s2_valid_r && !s2_go;
  assign accept   = in_valid && !in_stall;

  assign cnt_eff       = in_start_of_image ? '0 : col_cnt_r;
  assign halted_eff    = in_start_of_image ? 1'b0 : halted_r;
  assign first_row_eff = in_start_of_image ? 1'b1 : first_row_r;
  assign col           = AW'(cnt_eff - CW'(1));
  assign last          = LEN_W'(cnt_eff) >= row_len;

  always_comb begin
    col_cnt_nxt   = cnt_eff;
    filt_nxt      = filt_r;
    first_row_nxt = in_start_of_image ? 1'b1 : first_row_r;
    halted_nxt    = halted_eff;
    drop          = 1'b0;
    kind          = KIND_DATA;
    if (halted_eff) begin
      drop = 1'b1;
    end else if (cnt_eff == '0) begin
      if (in_data_byte > psu_pkg::FILT_MAX_BYTE) begin
        kind       = KIND_BAD;
        halted_nxt = 1'b1;
      end else begin
        kind        = KIND_FILT;
        filt_nxt    = in_data_byte[2:0];
        col_cnt_nxt = CW'(1);
      end
    end else begin
      kind = KIND_DATA;
      if (last) begin
        col_cnt_nxt   = '0;
        first_row_nxt = 1'b0;
      end else begin
        col_cnt_nxt = cnt_eff + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= '0;
      filt_r      <= psu_pkg::FILT_NONE;
      first_row_r <= 1'b1;
      halted_r    <= 1'b0;
    end else if (accept) begin
      col_cnt_r   <= col_cnt_nxt;
      filt_r      <= filt_nxt;
      first_row_r <= first_row_nxt;
      halted_r    <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (accept && !drop) begin
      s2_valid_r <= 1'b1;
    end else if (s2_go) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !drop) begin
      s2_kind_r  <= kind;
      s2_byte_r  <= in_data_byte;
      s2_col_r   <= col;
      s2_last_r  <= last;
      s2_first_r <= first_row_nxt || (kind == KIND_DATA && last && first_row_eff);
      s2_filt_r  <= filt_r;
    end
  end

  assign rd_en = accept && !drop && (kind == KIND_DATA);

  assign tap    = color_mode_r ? 2'd2 : 2'd0;
  assign pa_a   = left_r[tap];
  assign pa_c   = upleft_r[tap];
  assign pa_b   = s2_first_r ? 8'h00 : rd_data_r;
  assign avg_sum = {1'b0, pa_a} + {1'b0, pa_b};

  always_comb begin
    case (s2_filt_r)
      psu_pkg::FILT_SUB:   pred = pa_a;
      psu_pkg::FILT_UP:    pred = pa_b;
      psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
      psu_pkg::FILT_PAETH: pred = psu_pkg::paeth_pick(pa_a, pa_b, pa_c);
      default:             pred = 8'h00;
    endcase
  end

  assign recon = s2_byte_r + pred;
  assign wr_en = s2_go && (s2_kind_r == KIND_DATA);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[s2_col_r] <= recon;
    end
    if (rd_en) begin
      rd_data_r <= row_mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        left_r[i]   <= 8'h00;
        upleft_r[i] <= 8'h00;
      end
    end else if (s2_go) begin
      if (s2_kind_r == KIND_DATA) begin
        left_r[2]   <= left_r[1];
        left_r[1]   <= left_r[0];
        left_r[0]   <= recon;
        upleft_r[2] <= upleft_r[1];
        upleft_r[1] <= upleft_r[0];
        upleft_r[0] <= pa_b;
      end else begin
        for (int i = 0; i < 3; i++) begin
          left_r[i]   <= 8'h00;
          upleft_r[i] <= 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go && (s2_kind_r != KIND_FILT)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && (s2_kind_r != KIND_FILT)) begin
      out_pixel_r <= (s2_kind_r == KIND_DATA) ? recon : 8'h00;
      out_last_r  <= (s2_kind_r == KIND_DATA) && s2_last_r;
      out_bad_r   <= (s2_kind_r == KIND_BAD);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_byte  = out_pixel_r;
  assign out_last_in_row = out_last_r;
  assign out_bad_filter  = out_bad_r;

  a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (s2_col_r != col))
    else $error("row memory read and write hit the same entry");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && s2_valid_r))
    else $error("input stalled while the output side is free");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_cnt_r <= CW'(MAX_ROW_BYTES))
    else $error("column count beyond the row capacity");

  a_bad_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_go && s2_kind_r == KIND_BAD) |=> (out_valid_r && out_bad_r && out_pixel_r == 8'h00
                                          && !out_last_r))
    else $error("error item not presented as a zero byte");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the PNG scanline unfilter: directed rows, random images, APB setup.
`timescale 1ns / 1ps

module tb_top;

  localparam int ROW_CAP       = psu_pkg::MAX_ROW_BYTES_DEF;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int N_DIRECTED    = 23;
  localparam int NARROW_FIRST  = 6;
  localparam int N_SHAPES      = 9;
  localparam int PHASE_ITEMS   = 190;

  localparam logic [7:0] F_NONE  = 8'(psu_pkg::FILT_NONE);
  localparam logic [7:0] F_SUB   = 8'(psu_pkg::FILT_SUB);
  localparam logic [7:0] F_UP    = 8'(psu_pkg::FILT_UP);
  localparam logic [7:0] F_AVG   = 8'(psu_pkg::FILT_AVG);
  localparam logic [7:0] F_PAETH = 8'(psu_pkg::FILT_PAETH);
  localparam logic [7:0] F_BAD   = psu_pkg::FILT_MAX_BYTE + 8'd1;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
    logic       bad;
  } pixel_t;

  typedef struct packed {
    logic [7:0] data;
    logic       sop;
    logic       typed;
    logic       has_res;
    pixel_t     res;
  } offered_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [7:0]                    in_data_byte = 8'h00;
  logic                          in_start_of_image = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [7:0]                    out_pixel_byte;
  logic                          out_last_in_row;
  logic                          out_bad_filter;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [psu_pkg::PADDR_W-1:0]   paddr = '0;
  logic [31:0]                   pwdata = 32'h0;
  logic [31:0]                   prdata;
  logic                          pready;

  png_scanline_unfilter_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_start_of_image (in_start_of_image),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_byte    (out_pixel_byte),
    .out_last_in_row   (out_last_in_row),
    .out_bad_filter    (out_bad_filter),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #6 clk = ~clk;

  // shadow of the unfilter state
  logic [12:0] model_width = psu_pkg::IMAGE_WIDTH_RST;
  logic        model_color = psu_pkg::COLOR_MODE_RST;
  logic [7:0]  prev_row [ROW_CAP];
  logic [7:0]  left_hist [3];
  logic [7:0]  upleft_hist [3];
  int          col_count = 0;
  logic [2:0]  row_filter = psu_pkg::FILT_NONE;
  logic        first_row = 1'b1;
  logic        halted = 1'b0;

  offered_t    offered_bytes [$];
  pixel_t      expected_pixels [$];
  offered_t    directed_rows [N_DIRECTED];
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycles = 0;
  int          calm_left = 0;
  bit          pressure_done = 1'b0;

  initial begin
    foreach (left_hist[i]) begin
      left_hist[i] = 8'h00;
      upleft_hist[i] = 8'h00;
    end
  end

  function automatic int row_span();
    int w;
    int span;
    w = (model_width == 13'd0) ? 1 : int'(model_width);
    span = w * (model_color ? 3 : 1);
    return (span > ROW_CAP) ? ROW_CAP : span;
  endfunction

  function automatic logic [7:0] paeth_choose(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
    int est;
    int da;
    int db;
    int dc;
    est = int'(a) + int'(b) - int'(c);
    da = est - int'(a);
    db = est - int'(b);
    dc = est - int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  task automatic unfilter_byte(input logic [7:0] x, input logic sop, output logic got,
                               output pixel_t px);
    int bpp;
    int span;
    int col;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] pred;
    logic [8:0] sum;
    logic [7:0] r;
    got = 1'b0;
    px = '0;
    bpp = model_color ? 3 : 1;
    span = row_span();
    if (sop) begin
      halted = 1'b0;
      first_row = 1'b1;
      col_count = 0;
    end
    if (halted) return;
    if (col_count == 0) begin
      foreach (left_hist[i]) begin
        left_hist[i] = 8'h00;
        upleft_hist[i] = 8'h00;
      end
      if (x > psu_pkg::FILT_MAX_BYTE) begin
        halted = 1'b1;
        got = 1'b1;
        px.bad = 1'b1;
        return;
      end
      row_filter = x[2:0];
      col_count = 1;
      return;
    end
    col = col_count - 1;
    a = left_hist[bpp-1];
    c = upleft_hist[bpp-1];
    b = first_row ? 8'h00 : prev_row[col];
    sum = {1'b0, a} + {1'b0, b};
    case (row_filter)
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = sum[8:1];
      psu_pkg::FILT_PAETH: pred = paeth_choose(a, b, c);
      default:             pred = 8'h00;
    endcase
    r = x + pred;
    left_hist[2] = left_hist[1];
    left_hist[1] = left_hist[0];
    left_hist[0] = r;
    upleft_hist[2] = upleft_hist[1];
    upleft_hist[1] = upleft_hist[0];
    upleft_hist[0] = b;
    prev_row[col] = r;
    if (col + 1 >= span) begin
      col_count = 0;
      first_row = 1'b0;
      px.last = 1'b1;
    end else begin
      col_count++;
    end
    got = 1'b1;
    px.pixel = r;
  endtask

  always @(posedge clk) begin
    offered_t rec;
    logic got;
    pixel_t px;
    pixel_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) begin
      rec = offered_bytes.pop_front();
      unfilter_byte(rec.data, rec.sop, got, px);
      if (rec.typed) begin
        got = rec.has_res;
        px = rec.res;
      end
      if (got) expected_pixels.push_back(px);
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item pixel %h last %b bad %b", $time, out_pixel_byte,
                 out_last_in_row, out_bad_filter);
      end else begin
        want = expected_pixels.pop_front();
        if (out_pixel_byte !== want.pixel) begin
          mismatches++;
          $display("%0t: pixel_byte expected %h actual %h", $time, want.pixel, out_pixel_byte);
        end
        if (out_last_in_row !== want.last) begin
          mismatches++;
          $display("%0t: last_in_row expected %b actual %b", $time, want.last,
                   out_last_in_row);
        end
        if (out_bad_filter !== want.bad) begin
          mismatches++;
          $display("%0t: bad_filter expected %b actual %b", $time, want.bad, out_bad_filter);
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off to back up the pipeline
  initial begin
    int r;
    int hold;
    forever begin
      @(posedge clk);
      if (!pressure_done && results_seen >= 300) begin
        pressure_done = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall <= 1'b0;
          hold = $urandom_range(1, 12);
        end else if (r < 80) begin
          out_stall <= 1'b1;
          hold = $urandom_range(1, 3);
        end else if (r < 92) begin
          out_stall <= 1'b0;
          hold = $urandom_range(40, 150);
        end else begin
          out_stall <= 1'b1;
          hold = $urandom_range(10, 40);
        end
        repeat (hold - 1) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    if (r < 97) return $urandom_range(20, 40);
    calm_left = $urandom_range(30, 100);
    return 0;
  endfunction

  task automatic send_item(input offered_t rec);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offered_bytes.push_back(rec);
    in_valid <= 1'b1;
    in_data_byte <= rec.data;
    in_start_of_image <= rec.sop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic offer(input logic [7:0] data, input logic sop);
    send_item('{data, sop, 1'b0, 1'b0, '0});
  endtask

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_filter();
    if ($urandom_range(0, 99) < 92) return 8'($urandom_range(0, psu_pkg::FILT_MAX_BYTE));
    return 8'($urandom_range(psu_pkg::FILT_MAX_BYTE + 1, 255));
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_register(input logic regsel, input logic [31:0] value);
    logic [31:0] want;
    logic [31:0] got;
    want = (regsel == psu_pkg::REG_IMAGE_WIDTH) ? {19'd0, value[12:0]} : {31'd0, value[0]};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regsel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (regsel == psu_pkg::REG_IMAGE_WIDTH) model_width = value[12:0];
    else model_color = value[0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== want) begin
      mismatches++;
      $display("%0t: register %0d expected %h actual %h", $time, regsel, want, got);
    end
  endtask

  task automatic set_shape(input int width, input logic color);
    program_register(psu_pkg::REG_IMAGE_WIDTH, 32'(width));
    program_register(psu_pkg::REG_COLOR_MODE, {31'd0, color});
  endtask

  task automatic run_phase(input int budget, input bit fresh, input int tail);
    int sent;
    int span;
    int len;
    int rows;
    logic [7:0] f;
    sent = 0;
    span = row_span();
    if (!fresh) begin
      repeat ($urandom_range(1, 8)) begin
        offer(rand_byte(), 1'b0);
        sent++;
      end
    end
    while (sent < budget) begin
      rows = $urandom_range(1, 5);
      for (int r = 0; r < rows; r++) begin
        f = rand_filter();
        offer(f, r == 0);
        sent++;
        if (f > psu_pkg::FILT_MAX_BYTE) begin
          repeat ($urandom_range(0, 6)) offer(rand_byte(), 1'b0);
          break;
        end
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, span - 1) : span;
        repeat (len) begin
          offer(rand_byte(), 1'b0);
          sent++;
        end
        if (len < span) break;
      end
    end
    if (tail > 0) begin
      offer(F_SUB, 1'b1);
      repeat (tail) offer(rand_byte(), 1'b0);
    end
  endtask

  initial begin
    int   shape_w [N_SHAPES];
    bit   shape_c [N_SHAPES];
    bit   shape_fresh [N_SHAPES];
    int   shape_tail [N_SHAPES];
    int   drain;
    shape_w     = '{1, 0, 3, 16, 5, 4, 4, 7, 2};
    shape_c     = '{0, 1, 1, 0, 0, 1, 0, 1, 0};
    shape_fresh = '{1, 1, 1, 1, 0, 1, 0, 1, 1};
    shape_tail  = '{0, 0, 0, 10, 0, 7, 0, 0, 0};
    directed_rows = '{
      '{F_SUB,   1'b0, 1'b1, 1'b0, '0},
      '{8'h10,   1'b0, 1'b1, 1'b1, '{8'h10, 1'b0, 1'b0}},
      '{8'hFF,   1'b0, 1'b1, 1'b1, '{8'h0F, 1'b0, 1'b0}},
      '{F_BAD,   1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{8'h55,   1'b0, 1'b1, 1'b0, '0},
      '{8'h00,   1'b0, 1'b1, 1'b0, '0},
      '{F_NONE,  1'b1, 1'b1, 1'b0, '0},
      '{8'h00,   1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{8'hFF,   1'b0, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0}},
      '{F_SUB,   1'b0, 1'b1, 1'b0, '0},
      '{8'h80,   1'b0, 1'b0, 1'b0, '0},
      '{8'h90,   1'b0, 1'b0, 1'b0, '0},
      '{F_UP,    1'b0, 1'b1, 1'b0, '0},
      '{8'hC8,   1'b0, 1'b0, 1'b0, '0},
      '{8'h3C,   1'b0, 1'b0, 1'b0, '0},
      '{F_AVG,   1'b0, 1'b1, 1'b0, '0},
      '{8'h11,   1'b0, 1'b0, 1'b0, '0},
      '{8'hEE,   1'b0, 1'b0, 1'b0, '0},
      '{F_PAETH, 1'b0, 1'b1, 1'b0, '0},
      '{8'h5A,   1'b0, 1'b0, 1'b0, '0},
      '{8'hA5,   1'b0, 1'b0, 1'b0, '0},
      '{8'hFF,   1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{8'h00,   1'b0, 1'b1, 1'b0, '0}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (i == NARROW_FIRST) begin
        settle();
        set_shape(2, 1'b0);
      end
      send_item(directed_rows[i]);
    end

    for (int p = 0; p < N_SHAPES; p++) begin
      settle();
      set_shape(shape_w[p], shape_c[p]);
      run_phase(PHASE_ITEMS, shape_fresh[p], shape_tail[p]);
    end

    settle();
    set_shape(1, 1'b1);
    run_phase(60, 1'b1, 0);

    in_valid <= 1'b0;
    drain = 0;
    while (expected_pixels.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected items never arrived, next pixel %h", $time,
               expected_pixels.size(), expected_pixels[0].pixel);
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
